// File: design/graph6_stream_decoder_unit_defines.svh
// Assertion macros shared by the graph6 stream decoder RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef GRAPH6_STREAM_DECODER_UNIT_DEFINES_SVH
`define GRAPH6_STREAM_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define G6SD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define G6SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define G6SD_ASSERT_NOW(lbl, ante, cons, msg)
`define G6SD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/g6sd_pkg.sv
// Package for the graph6 stream decoder: types, constants, header text.
// Depends on nothing; used by every module of the decoder.
`default_nettype none

package g6sd_pkg;

  localparam int COUNT_BITS = 18;
  localparam int NODE_BITS  = 18;
  localparam int BYTE_BITS  = 8;
  localparam int GROUP_BITS = 6;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_BITS-1:0] BYTE_NEWLINE  = 8'h0A;
  localparam logic [BYTE_BITS-1:0] BYTE_LONG     = 8'd126;
  localparam logic [BYTE_BITS-1:0] BYTE_OFFSET   = 8'd63;
  localparam logic [BYTE_BITS-1:0] BYTE_HDR_OPEN = 8'h3E;

  localparam logic [3:0] HDR_LEN    = 4'd10;
  localparam logic [2:0] GROUP_STEPS = 3'd6;
  localparam logic [1:0] LONG_GROUPS = 2'd3;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [COUNT_BITS:0]   count_ext_t;
  typedef logic [NODE_BITS-1:0]  node_t;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HDR_START   = 3'd0,
    PH_HDR_MATCH   = 3'd1,
    PH_COUNT_FIRST = 3'd2,
    PH_COUNT_LONG  = 3'd3,
    PH_DATA        = 3'd4,
    PH_DONE        = 3'd5,
    PH_ERROR       = 3'd6
  } phase_t;

  // One classified byte, as the front hands it to the edge walker.
  typedef struct packed {
    logic                  walk_reset;
    logic                  pre_valid;
    kind_t                 pre_kind;
    logic                  data_valid;
    logic [GROUP_BITS-1:0] data_bits;
    logic                  done;
    count_t                count;
  } cmd_t;

  function automatic logic [BYTE_BITS-1:0] hdr_char(input logic [3:0] pos);
    logic [BYTE_BITS-1:0] c;
    case (pos)
      4'd0:    c = 8'h3E;
      4'd1:    c = 8'h3E;
      4'd2:    c = 8'h67;
      4'd3:    c = 8'h72;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h70;
      4'd6:    c = 8'h68;
      4'd7:    c = 8'h36;
      4'd8:    c = 8'h3C;
      4'd9:    c = 8'h3C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/graph6_stream_decoder_unit.sv
// Path: a byte's command is written to the queue, loaded into the walker registers, and
// its result is registered on the output port. Throughput: bytes with no result and no
// file start skip the walker; a data byte is walked one triangle bit per cycle while the
// output is not stalled on a result. The four-deep queue lets bytes arrive while the
// walker works. Reset (rst, synchronous) empties the queue and returns to header check
// with row one, column zero.
`default_nettype none

module graph6_stream_decoder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [g6sd_pkg::BYTE_BITS-1:0]  data_byte,
  input  wire logic                            start_of_file,
  input  wire logic                            end_of_file,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           kind,
  output logic [g6sd_pkg::NODE_BITS-1:0]       edge_row,
  output logic [g6sd_pkg::NODE_BITS-1:0]       edge_col,
  output logic [g6sd_pkg::NODE_BITS-1:0]       node_total,
  output logic                                 last
);

  // Front to queue.
  logic           q_push;
  logic           q_full;
  g6sd_pkg::cmd_t push_cmd;

  // Queue to walker.
  logic           q_pop;
  logic           q_empty;
  g6sd_pkg::cmd_t head_cmd;

  // Classify each item: track the header, build the node count, and turn
  // every byte that carries results into one command. The front stalls
  // only when the queue is full.
  g6sd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .end_of_file   (end_of_file),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // Hold commands so a slow sink does not block byte intake.
  g6sd_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (head_cmd),
    .empty   (q_empty)
  );

  // Walk the triangle and drive the registered result port. The walker
  // advances through zero bits even while the output stalls, and only
  // waits when it has a result to hand over.
  g6sd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .edge_row   (edge_row),
    .edge_col   (edge_col),
    .node_total (node_total),
    .last       (last)
  );

endmodule

`default_nettype wire

// File: design/g6sd_cmd_fifo.sv
// Short command queue between the byte classifier and the edge walker.
// Depends on g6sd_pkg for cmd_t and the queue depth.
`default_nettype none

module g6sd_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire g6sd_pkg::cmd_t  cmd_in,
  output logic                 full,
  input  wire logic            pop,
  output g6sd_pkg::cmd_t       cmd_out,
  output logic                 empty
);

  g6sd_pkg::cmd_t                        entries [g6sd_pkg::FIFO_DEPTH];
  logic [g6sd_pkg::FIFO_PTR_W-1:0]       wr_ptr;
  logic [g6sd_pkg::FIFO_PTR_W-1:0]       rd_ptr;
  logic [g6sd_pkg::FIFO_CNT_W-1:0]       fill;

  assign full    = (fill == g6sd_pkg::FIFO_CNT_W'(g6sd_pkg::FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign cmd_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/g6sd_front.sv
// Byte classifier: header match, node count decode, file phase tracking.
// Depends on g6sd_pkg; feeds one command per result-bearing byte to the queue.
`default_nettype none

module g6sd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [g6sd_pkg::BYTE_BITS-1:0] data_byte,
  input  wire logic                          start_of_file,
  input  wire logic                          end_of_file,
  input  wire logic                          q_full,
  output logic                               q_push,
  output g6sd_pkg::cmd_t                     q_cmd
);

  g6sd_pkg::phase_t phase, phase_byte, phase_next, cur_phase;
  logic [3:0]       hdr_pos, hdr_pos_next, cur_pos;
  g6sd_pkg::count_t acc, acc_next, cur_acc;
  logic [1:0]       bytes_left, bytes_left_next, cur_left, left_dec;
  logic             count_known, known_next, cur_known;

  logic [g6sd_pkg::BYTE_BITS-1:0]  byte_sub;
  logic [g6sd_pkg::GROUP_BITS-1:0] value6;
  logic                            is_nl, is_long, hdr_ok, take_first, accept;

  // A start-of-file byte sees the decoder as freshly reset.
  assign cur_phase = start_of_file ? g6sd_pkg::PH_HDR_START : phase;
  assign cur_pos   = start_of_file ? 4'd0 : hdr_pos;
  assign cur_acc   = start_of_file ? '0 : acc;
  assign cur_left  = start_of_file ? 2'd0 : bytes_left;
  assign cur_known = start_of_file ? 1'b0 : count_known;

  assign byte_sub   = data_byte - g6sd_pkg::BYTE_OFFSET;
  assign value6     = byte_sub[g6sd_pkg::GROUP_BITS-1:0];
  assign is_nl      = (data_byte == g6sd_pkg::BYTE_NEWLINE);
  assign is_long    = (data_byte == g6sd_pkg::BYTE_LONG);
  assign hdr_ok     = (cur_pos < g6sd_pkg::HDR_LEN) &&
                      (data_byte == g6sd_pkg::hdr_char(cur_pos));
  assign left_dec   = (cur_left != 2'd0) ? cur_left - 2'd1 : 2'd0;
  assign take_first = ((cur_phase == g6sd_pkg::PH_HDR_START) &&
                       (data_byte != g6sd_pkg::BYTE_HDR_OPEN)) ||
                      (cur_phase == g6sd_pkg::PH_COUNT_FIRST);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    phase_byte      = cur_phase;
    hdr_pos_next    = cur_pos;
    acc_next        = cur_acc;
    bytes_left_next = cur_left;
    known_next      = cur_known;
    if (take_first) begin
      if (is_nl) begin
        phase_byte = g6sd_pkg::PH_DONE;
      end else if (is_long) begin
        phase_byte      = g6sd_pkg::PH_COUNT_LONG;
        bytes_left_next = g6sd_pkg::LONG_GROUPS;
        acc_next        = '0;
      end else begin
        acc_next   = g6sd_pkg::count_t'(value6);
        known_next = 1'b1;
        phase_byte = g6sd_pkg::PH_DATA;
      end
    end
    case (cur_phase)
      g6sd_pkg::PH_HDR_START: begin
        if (data_byte == g6sd_pkg::BYTE_HDR_OPEN) begin
          phase_byte   = g6sd_pkg::PH_HDR_MATCH;
          hdr_pos_next = 4'd1;
        end
      end
      g6sd_pkg::PH_HDR_MATCH: begin
        if (hdr_ok) begin
          hdr_pos_next = cur_pos + 4'd1;
          if (cur_pos + 4'd1 >= g6sd_pkg::HDR_LEN) begin
            phase_byte = g6sd_pkg::PH_COUNT_FIRST;
          end
        end else begin
          phase_byte = g6sd_pkg::PH_ERROR;
        end
      end
      g6sd_pkg::PH_COUNT_LONG: begin
        if (is_nl) begin
          phase_byte = g6sd_pkg::PH_DONE;
        end else begin
          acc_next        = (cur_acc << g6sd_pkg::GROUP_BITS) | g6sd_pkg::count_t'(value6);
          bytes_left_next = left_dec;
          if (left_dec == 2'd0) begin
            known_next = 1'b1;
            phase_byte = g6sd_pkg::PH_DATA;
          end
        end
      end
      g6sd_pkg::PH_DATA: begin
        if (is_nl) begin
          phase_byte = g6sd_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
    phase_next = phase_byte;
    if (end_of_file) begin
      if (phase_byte == g6sd_pkg::PH_HDR_MATCH) begin
        phase_next = g6sd_pkg::PH_ERROR;
      end else if (!(phase_byte inside {g6sd_pkg::PH_DONE, g6sd_pkg::PH_ERROR})) begin
        phase_next = g6sd_pkg::PH_DONE;
      end
    end
  end

  // Command for the walker.
  always_comb begin
    q_cmd            = '0;
    q_cmd.walk_reset = start_of_file;
    q_cmd.pre_kind   = g6sd_pkg::KIND_COUNT;
    q_cmd.data_bits  = value6;
    q_cmd.count      = known_next ? acc_next : '0;
    if (take_first) begin
      if (is_nl) begin
        q_cmd.done = 1'b1;
      end else if (!is_long) begin
        q_cmd.pre_valid = 1'b1;
      end
    end
    case (cur_phase)
      g6sd_pkg::PH_HDR_MATCH: begin
        if (!hdr_ok) begin
          q_cmd.pre_valid = 1'b1;
          q_cmd.pre_kind  = g6sd_pkg::KIND_ERROR;
        end
      end
      g6sd_pkg::PH_COUNT_LONG: begin
        if (is_nl) begin
          q_cmd.done = 1'b1;
        end else if (left_dec == 2'd0) begin
          q_cmd.pre_valid = 1'b1;
        end
      end
      g6sd_pkg::PH_DATA: begin
        if (is_nl) begin
          q_cmd.done = 1'b1;
        end else begin
          q_cmd.data_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (end_of_file) begin
      if (phase_byte == g6sd_pkg::PH_HDR_MATCH) begin
        q_cmd.pre_valid = 1'b1;
        q_cmd.pre_kind  = g6sd_pkg::KIND_ERROR;
      end else if (!(phase_byte inside {g6sd_pkg::PH_DONE, g6sd_pkg::PH_ERROR})) begin
        q_cmd.done = 1'b1;
      end
    end
  end

  // Drop bytes that neither emit nor restart the walker.
  assign q_push = accept &&
                  (start_of_file || q_cmd.pre_valid || q_cmd.data_valid || q_cmd.done);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= g6sd_pkg::PH_HDR_START;
      hdr_pos     <= 4'd0;
      acc         <= '0;
      bytes_left  <= 2'd0;
      count_known <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      hdr_pos     <= hdr_pos_next;
      acc         <= acc_next;
      bytes_left  <= bytes_left_next;
      count_known <= known_next;
    end
  end

endmodule

`default_nettype wire

// File: design/g6sd_back.sv
// Edge walker: expands queued commands into results, at most one per cycle and only while
// the output is not stalled, walking the lower triangle. Depends on g6sd_pkg and the assertion macros.
`default_nettype none
`include "graph6_stream_decoder_unit_defines.svh"

module g6sd_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_empty,
  input  wire g6sd_pkg::cmd_t                  q_cmd,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           kind,
  output logic [g6sd_pkg::NODE_BITS-1:0]       edge_row,
  output logic [g6sd_pkg::NODE_BITS-1:0]       edge_col,
  output logic [g6sd_pkg::NODE_BITS-1:0]       node_total,
  output logic                                 last
);

  logic                            busy, busy_next;
  logic                            pre_pend, pre_pend_next;
  g6sd_pkg::kind_t                 pre_kind, pre_kind_next;
  logic [g6sd_pkg::GROUP_BITS-1:0] bits, bits_next;
  logic [2:0]                      bits_left, bits_left_next;
  logic                            done_pend, done_pend_next;
  logic [2:0]                      edge_cnt, edge_cnt_next;
  g6sd_pkg::count_t                count, count_next;
  g6sd_pkg::count_t                row, row_next, col, col_next, col_inc;

  g6sd_pkg::count_t                gap;
  g6sd_pkg::count_ext_t            gap_plus;
  logic                            in_tri, row1_in, row2_in, later;
  logic                            need, can_emit, step, rem, emit_fire;

  logic                            out_valid_next;
  logic [1:0]                      emit_kind;
  g6sd_pkg::count_t                emit_row, emit_col;
  logic                            emit_last;

  assign in_tri   = (row < count);
  assign gap      = row - col;
  assign gap_plus = g6sd_pkg::count_ext_t'(gap) + g6sd_pkg::count_ext_t'(row) +
                    g6sd_pkg::count_ext_t'(1);
  assign row1_in  = (g6sd_pkg::count_ext_t'(row) + g6sd_pkg::count_ext_t'(1)) <
                    g6sd_pkg::count_ext_t'(count);
  assign row2_in  = (g6sd_pkg::count_ext_t'(row) + g6sd_pkg::count_ext_t'(2)) <
                    g6sd_pkg::count_ext_t'(count);
  assign col_inc  = col + 1'b1;

  // Any set bit still ahead in this byte that lands inside the triangle.
  // Rows after the next one already hold more than the five bits left.
  always_comb begin
    later = 1'b0;
    for (int t = 1; t < g6sd_pkg::GROUP_BITS; t++) begin
      later = later || (bits[g6sd_pkg::GROUP_BITS-1-t] && (3'(t) < bits_left) &&
                        ((g6sd_pkg::count_t'(t) < gap) ||
                         (row1_in && ((g6sd_pkg::count_ext_t'(t) < gap_plus) || row2_in))));
    end
  end

  // Pick this cycle's step and what it would emit.
  always_comb begin
    need      = 1'b0;
    rem       = 1'b0;
    emit_kind = g6sd_pkg::KIND_DONE;
    emit_row  = '0;
    emit_col  = '0;
    emit_last = 1'b1;
    if (pre_pend) begin
      need      = 1'b1;
      emit_kind = pre_kind;
      emit_last = !done_pend;
      rem       = done_pend || (bits_left != 3'd0);
    end else if (bits_left != 3'd0) begin
      need      = in_tri && bits[g6sd_pkg::GROUP_BITS-1];
      emit_kind = g6sd_pkg::KIND_EDGE;
      emit_row  = row;
      emit_col  = col;
      emit_last = !later && (!done_pend || (edge_cnt == g6sd_pkg::GROUP_STEPS - 3'd1));
      rem       = (in_tri && (bits_left != 3'd1)) || done_pend;
    end else if (done_pend) begin
      need = (edge_cnt != g6sd_pkg::GROUP_STEPS);
    end
  end

  assign can_emit  = !out_valid || out_ready;
  assign step      = busy && (!need || can_emit);
  assign emit_fire = step && need;
  assign q_pop     = !q_empty && (!busy || (step && !rem));

  // Walker state update.
  always_comb begin
    busy_next      = busy;
    pre_pend_next  = pre_pend;
    pre_kind_next  = pre_kind;
    bits_next      = bits;
    bits_left_next = bits_left;
    done_pend_next = done_pend;
    edge_cnt_next  = edge_cnt;
    count_next     = count;
    row_next       = row;
    col_next       = col;
    if (step) begin
      busy_next = rem;
      if (pre_pend) begin
        pre_pend_next = 1'b0;
      end else if (bits_left != 3'd0) begin
        if (in_tri) begin
          bits_next      = bits << 1;
          bits_left_next = bits_left - 3'd1;
          if (bits[g6sd_pkg::GROUP_BITS-1]) begin
            edge_cnt_next = edge_cnt + 3'd1;
          end
          if (col_inc >= row) begin
            row_next = row + 1'b1;
            col_next = '0;
          end else begin
            col_next = col_inc;
          end
        end else begin
          bits_left_next = 3'd0;
        end
      end else begin
        done_pend_next = 1'b0;
      end
    end
    if (q_pop) begin
      busy_next      = q_cmd.pre_valid || q_cmd.data_valid || q_cmd.done;
      pre_pend_next  = q_cmd.pre_valid;
      pre_kind_next  = q_cmd.pre_kind;
      bits_next      = q_cmd.data_bits;
      bits_left_next = q_cmd.data_valid ? g6sd_pkg::GROUP_STEPS : 3'd0;
      done_pend_next = q_cmd.done;
      edge_cnt_next  = 3'd0;
      count_next     = q_cmd.count;
      if (q_cmd.walk_reset) begin
        row_next = g6sd_pkg::count_t'(1);
        col_next = '0;
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (emit_fire) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pre_pend  <= 1'b0;
      bits_left <= 3'd0;
      done_pend <= 1'b0;
      row       <= g6sd_pkg::count_t'(1);
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      pre_pend  <= pre_pend_next;
      bits_left <= bits_left_next;
      done_pend <= done_pend_next;
      row       <= row_next;
      col       <= col_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pre_kind <= pre_kind_next;
    bits     <= bits_next;
    edge_cnt <= edge_cnt_next;
    count    <= count_next;
    if (emit_fire) begin
      kind       <= emit_kind;
      edge_row   <= g6sd_pkg::NODE_BITS'(emit_row);
      edge_col   <= g6sd_pkg::NODE_BITS'(emit_col);
      node_total <= g6sd_pkg::NODE_BITS'(count);
      last       <= emit_last;
    end
  end

  `G6SD_ASSERT_NOW(a_col_below_row, 1'b1, col < row, "walker column reached its row")
  `G6SD_ASSERT_NOW(a_edge_cnt_range, busy, edge_cnt <= g6sd_pkg::GROUP_STEPS, "edge count overrun")
  `G6SD_ASSERT_NEXT(a_edge_in_triangle, emit_fire && emit_kind == g6sd_pkg::KIND_EDGE, edge_row < node_total && edge_col < edge_row, "edge outside triangle")

endmodule

`default_nettype wire
